// ===== hdl/point_in_polygon_test_unit_defines.svh =====
// Assertion macros shared by the point-in-polygon test unit.
// Expects signals named clock and reset in the including scope.
`ifndef POINT_IN_POLYGON_TEST_UNIT_DEFINES_SVH
`define POINT_IN_POLYGON_TEST_UNIT_DEFINES_SVH

// Same-cycle implication, off while reset is high.
`define PIPT_ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pipt: assertion failed");

// Next-cycle implication, off while reset is high.
`define PIPT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pipt: assertion failed");

`endif

// ===== hdl/pipt_pkg.sv =====
// Types, constants and edge arithmetic for the point-in-polygon test unit.
// No dependencies; used by every module of the block.
package pipt_pkg;

   localparam int COORD_BITS      = 16;
   localparam int DIFF_BITS       = COORD_BITS + 1;
   localparam int PROD_BITS       = 2 * DIFF_BITS;
   localparam int MIN_CORNERS     = 3;
   localparam int QUEUE_DEPTH_DEF = 4;

   localparam logic [1:0] VERDICT_PARITY   = 2'd0;
   localparam logic [1:0] VERDICT_BOUNDARY = 2'd1;
   localparam logic [1:0] VERDICT_FEW      = 2'd2;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DIFF_BITS-1:0]  diff_type;
   typedef logic signed [PROD_BITS-1:0]  prod_type;
   typedef logic [1:0]                   count_type;

   typedef struct packed {
      coord_type query_x;
      coord_type query_y;
      coord_type corner_x;
      coord_type corner_y;
      logic      last_corner;
   } req_type;

   typedef struct packed {
      logic       is_inside;
      logic [1:0] verdict;
   } rsp_type;

   // One classified vertex, as handed from the front to the back.
   typedef struct packed {
      logic      start;
      logic      judge_prior;
      logic      last;
      logic      few;
      coord_type query_x;
      coord_type query_y;
      coord_type cur_x;
      coord_type cur_y;
      coord_type prior_x;
      coord_type prior_y;
      coord_type first_x;
      coord_type first_y;
   } job_type;

   typedef struct packed {
      logic space;
      logic avail;
   } q_status_type;

   // Registered products and compares of one edge.
   typedef struct packed {
      prod_type lhs;
      prod_type rhs;
      logic     in_box;
      logic     straddle;
      logic     dy_pos;
   } edge_terms_type;

   typedef struct packed {
      logic hit;
      logic crosses;
   } edge_flags_type;

   // Edge from (cx,cy) to (px,py) against query (qx,qy).
   function automatic edge_terms_type edge_terms(coord_type qx, coord_type qy,
                                                 coord_type cx, coord_type cy,
                                                 coord_type px, coord_type py);
      diff_type       dqx;
      diff_type       dqy;
      diff_type       dpx;
      diff_type       dy;
      edge_terms_type t;
      dqx        = DIFF_BITS'(qx) - DIFF_BITS'(cx);
      dqy        = DIFF_BITS'(qy) - DIFF_BITS'(cy);
      dpx        = DIFF_BITS'(px) - DIFF_BITS'(cx);
      dy         = DIFF_BITS'(py) - DIFF_BITS'(cy);
      t.lhs      = PROD_BITS'(dqx) * PROD_BITS'(dy);
      t.rhs      = PROD_BITS'(dpx) * PROD_BITS'(dqy);
      t.in_box   = ((qx >= cx) || (qx >= px)) && ((qx <= cx) || (qx <= px)) &&
                   ((qy >= cy) || (qy >= py)) && ((qy <= cy) || (qy <= py));
      t.straddle = (cy > qy) != (py > qy);
      t.dy_pos   = py > cy;
      return t;
   endfunction

   // Cross product zero inside the bounding box means the point lies on the edge.
   function automatic edge_flags_type judge_edge(edge_terms_type t);
      edge_flags_type f;
      prod_type       l;
      prod_type       r;
      l         = t.lhs;
      r         = t.rhs;
      f.hit     = (l == r) && t.in_box;
      f.crosses = t.straddle && (t.dy_pos ? (l < r) : (l > r));
      return f;
   endfunction

endpackage

// ===== hdl/point_in_polygon_test_unit.sv =====
// Point-in-polygon test unit. Vertices arrive one beat per cycle on req_ while
// req_ready is high; the first beat of a polygon also carries the query point,
// and the beat with last_corner set closes the polygon and produces one rsp_
// beat: is_inside with a verdict of parity decided, on boundary, or too few
// vertices. The block takes one vertex every cycle while the queue has space;
// each beat passes a front stage, a job queue of QUEUE_DEPTH entries, an edge
// product stage (two 17x17 multiplies per edge, prior edge and closing edge
// side by side) and the result register. A stalled result holds only the next
// last-vertex beat; the queue absorbs up to QUEUE_DEPTH beats before req_ready
// drops. Depends on pipt_pkg and the defines header.
`include "point_in_polygon_test_unit_defines.svh"

module point_in_polygon_test_unit #(
   parameter int QUEUE_DEPTH = pipt_pkg::QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pipt_pkg::req_type req_item,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pipt_pkg::rsp_type rsp_item
);
   import pipt_pkg::*;

   q_status_type q_status;
   job_type      push_job;
   job_type      head_job;
   logic         push;
   logic         pop;

   pipt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .q_status  (q_status),
      .push      (push),
      .job       (push_job)
   );

   pipt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .q_status (q_status)
   );

   pipt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .head_job  (head_job),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   `PIPT_ASSERT_IMPLIES(a_pop_needs_data, pop, q_status.avail)
   `PIPT_ASSERT_IMPLIES(a_push_needs_space, push, q_status.space)
   `PIPT_ASSERT_NEXT(a_push_fills_queue, push && !pop, q_status.avail)
   `PIPT_ASSERT_IMPLIES(a_inside_only_on_parity, rsp_valid && rsp_item.is_inside,
                        rsp_item.verdict == VERDICT_PARITY)
   `PIPT_ASSERT_IMPLIES(a_verdict_known, rsp_valid,
                        rsp_item.verdict == VERDICT_PARITY ||
                        rsp_item.verdict == VERDICT_BOUNDARY ||
                        rsp_item.verdict == VERDICT_FEW)

endmodule

// ===== hdl/pipt_front.sv =====
// Front of the point-in-polygon test unit: accepts vertex beats, tracks
// polygon state and pushes classified jobs. Depends on pipt_pkg.
module pipt_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  pipt_pkg::req_type      req_item,
   input  pipt_pkg::q_status_type q_status,
   output logic                   push,
   output pipt_pkg::job_type      job
);
   import pipt_pkg::*;

   count_type count_ff, count_in;
   coord_type held_x_ff, held_x_in;
   coord_type held_y_ff, held_y_in;
   coord_type first_x_ff, first_x_in;
   coord_type first_y_ff, first_y_in;
   coord_type prior_x_ff, prior_x_in;
   coord_type prior_y_ff, prior_y_in;
   logic      starting;

   always_comb begin
      starting  = count_ff == '0;
      req_ready = q_status.space;
      push      = req_valid && q_status.space;

      job.start       = starting;
      job.judge_prior = !starting;
      job.last        = req_item.last_corner;
      job.few         = count_ff < count_type'(MIN_CORNERS - 1);
      job.query_x     = starting ? req_item.query_x : held_x_ff;
      job.query_y     = starting ? req_item.query_y : held_y_ff;
      job.cur_x       = req_item.corner_x;
      job.cur_y       = req_item.corner_y;
      job.prior_x     = prior_x_ff;
      job.prior_y     = prior_y_ff;
      job.first_x     = starting ? req_item.corner_x : first_x_ff;
      job.first_y     = starting ? req_item.corner_y : first_y_ff;

      count_in   = count_ff;
      held_x_in  = held_x_ff;
      held_y_in  = held_y_ff;
      first_x_in = first_x_ff;
      first_y_in = first_y_ff;
      prior_x_in = prior_x_ff;
      prior_y_in = prior_y_ff;
      if (push) begin
         if (starting) begin
            held_x_in  = req_item.query_x;
            held_y_in  = req_item.query_y;
            first_x_in = req_item.corner_x;
            first_y_in = req_item.corner_y;
         end
         prior_x_in = req_item.corner_x;
         prior_y_in = req_item.corner_y;
         // saturate at the minimum polygon size; drop back to zero after the last beat
         if (req_item.last_corner) begin
            count_in = '0;
         end else if (count_ff != count_type'(MIN_CORNERS)) begin
            count_in = count_ff + count_type'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      held_x_ff  <= held_x_in;
      held_y_ff  <= held_y_in;
      first_x_ff <= first_x_in;
      first_y_ff <= first_y_in;
      prior_x_ff <= prior_x_in;
      prior_y_ff <= prior_y_in;
   end

endmodule

// ===== hdl/pipt_queue.sv =====
// Short job queue between the front and the back of the point-in-polygon
// test unit. Depends on pipt_pkg.
module pipt_queue #(
   parameter int DEPTH = pipt_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  pipt_pkg::job_type      push_job,
   input  logic                   pop,
   output pipt_pkg::job_type      head_job,
   output pipt_pkg::q_status_type q_status
);
   import pipt_pkg::*;

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   typedef logic [PTR_BITS-1:0] ptr_type;
   typedef logic [CNT_BITS-1:0] cnt_type;

   job_type entry_ff [DEPTH];
   ptr_type wr_ptr_ff, wr_ptr_in;
   ptr_type rd_ptr_ff, rd_ptr_in;
   cnt_type count_ff, count_in;

   function automatic ptr_type ptr_next(ptr_type p);
      return (p == ptr_type'(DEPTH - 1)) ? '0 : p + ptr_type'(1);
   endfunction

   always_comb begin
      head_job       = entry_ff[rd_ptr_ff];
      q_status.space = count_ff != cnt_type'(DEPTH);
      q_status.avail = count_ff != '0;

      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + cnt_type'(1);
      end else if (pop && !push) begin
         count_in = count_ff - cnt_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== hdl/pipt_back.sv =====
// Back of the point-in-polygon test unit: edge products stage, parity and
// boundary update, and the result register. Depends on pipt_pkg.
module pipt_back (
   input  logic                   clock,
   input  logic                   reset,
   input  pipt_pkg::q_status_type q_status,
   input  pipt_pkg::job_type      head_job,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output pipt_pkg::rsp_type      rsp_item
);
   import pipt_pkg::*;

   typedef struct packed {
      logic           start;
      logic           judge_prior;
      logic           last;
      logic           few;
      logic           close;
      edge_terms_type prior_edge;
      edge_terms_type close_edge;
   } stage_type;

   logic           p_valid_ff, p_valid_in;
   stage_type      p_ff, p_in;
   logic           parity_ff, parity_in;
   logic           hit_ff, hit_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_ff, rsp_in;
   logic           out_free;
   logic           p_go;
   logic           par_next;
   logic           hit_next;
   edge_flags_type prior_flags;
   edge_flags_type close_flags;

   always_comb begin
      out_free = !rsp_valid_ff || rsp_ready;
      // only a last beat needs the result register
      p_go     = p_valid_ff && (!p_ff.last || out_free);
      pop      = q_status.avail && (!p_valid_ff || p_go);

      p_in.start       = head_job.start;
      p_in.judge_prior = head_job.judge_prior;
      p_in.last        = head_job.last;
      p_in.few         = head_job.few;
      p_in.close       = head_job.last && !head_job.few;
      p_in.prior_edge  = edge_terms(head_job.query_x, head_job.query_y,
                                    head_job.cur_x, head_job.cur_y,
                                    head_job.prior_x, head_job.prior_y);
      p_in.close_edge  = edge_terms(head_job.query_x, head_job.query_y,
                                    head_job.first_x, head_job.first_y,
                                    head_job.cur_x, head_job.cur_y);

      if (pop) begin
         p_valid_in = 1'b1;
      end else if (p_go) begin
         p_valid_in = 1'b0;
      end else begin
         p_valid_in = p_valid_ff;
      end

      prior_flags = judge_edge(p_ff.prior_edge);
      close_flags = judge_edge(p_ff.close_edge);
      par_next = (p_ff.start ? 1'b0 : parity_ff)
               ^ (p_ff.judge_prior & prior_flags.crosses)
               ^ (p_ff.close & close_flags.crosses);
      hit_next = (p_ff.start ? 1'b0 : hit_ff)
               | (p_ff.judge_prior & prior_flags.hit)
               | (p_ff.close & close_flags.hit);

      parity_in = p_go ? par_next : parity_ff;
      hit_in    = p_go ? hit_next : hit_ff;

      if (p_go && p_ff.last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      rsp_in = rsp_ff;
      if (p_go && p_ff.last) begin
         priority if (p_ff.few) begin
            rsp_in.is_inside = 1'b0;
            rsp_in.verdict   = VERDICT_FEW;
         end else if (hit_next) begin
            rsp_in.is_inside = 1'b0;
            rsp_in.verdict   = VERDICT_BOUNDARY;
         end else begin
            rsp_in.is_inside = par_next;
            rsp_in.verdict   = VERDICT_PARITY;
         end
      end

      rsp_valid = rsp_valid_ff;
      rsp_item  = rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff   <= 1'b0;
         parity_ff    <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         p_valid_ff   <= p_valid_in;
         parity_ff    <= parity_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         p_ff <= p_in;
      end
      rsp_ff <= rsp_in;
   end

endmodule
